[rtl/core/butterworth_spectrum_gain_macros.svh]
// Assertion macros for the butterworth spectrum gain block.
// Used by the top level only; no other dependencies.
`ifndef BUTTERWORTH_SPECTRUM_GAIN_MACROS_SVH
`define BUTTERWORTH_SPECTRUM_GAIN_MACROS_SVH
`ifndef SYNTH
`define BSG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define BSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BSG_ASSERT(lbl, clk, rst_n, prop)
`define BSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/bsg_pkg.sv]
// Shared constants, codes and request/response types of the spectrum gain block.
// No dependencies.
package bsg_pkg;

    localparam int MAX_SIDE       = 4096;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int GAIN_W         = GAIN_FRAC_BITS + 1;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 3;

    localparam int OP_W       = 27;
    localparam int PQ_W       = 2 * OP_W;
    localparam int T_FRAC     = 32;
    localparam int T_INT      = 26;
    localparam int QUO_W      = T_FRAC + T_INT;
    localparam int T_W        = QUO_W + 1;
    localparam int MUL_COUNT  = 6;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BW_BINS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NOTCH_U0   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NOTCH_V0   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER      = 3'd7;

    localparam logic [2:0] FT_LOW   = 3'd0;
    localparam logic [2:0] FT_HIGH  = 3'd1;
    localparam logic [2:0] FT_BREJ  = 3'd2;
    localparam logic [2:0] FT_BPASS = 3'd3;
    localparam logic [2:0] FT_NOTCH = 3'd4;

    localparam logic [T_W-1:0]    T_CAP     = T_W'(1) << QUO_W;
    localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(1) << GAIN_FRAC_BITS;

    typedef struct packed {
        logic [11:0] col;
        logic [11:0] row;
        logic [31:0] amplitude_in;
    } t_in_req;

    typedef struct packed {
        logic [31:0]       amplitude_out;
        logic [GAIN_W-1:0] gain;
    } t_out_rsp;

    typedef struct packed {
        logic [12:0]        width;
        logic [12:0]        height;
        logic [2:0]         filter_type;
        logic [12:0]        cutoff;
        logic [12:0]        bw_bins;
        logic signed [12:0] notch_u0;
        logic signed [12:0] notch_v0;
        logic [2:0]         order;
    } t_cfg;

    typedef struct packed {
        logic [PQ_W-1:0] p;
        logic [PQ_W-1:0] q;
        logic [31:0]     amp;
    } t_pq;

    typedef struct packed {
        logic [T_W-1:0] val;
        logic           zero;
        logic [31:0]    amp;
    } t_val;

endpackage

[rtl/core/bsg_front.sv]
// Front end: centers the position, forms squared radii and the ratio terms P and Q.
// Depends on bsg_pkg.
module bsg_front
    import bsg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_in_req i_req,
    input  t_cfg    i_cfg,
    output logic    o_valid,
    output t_pq     o_pq
);

    logic [4:0] r_vld;

    logic [11:0]        half_w, half_h;
    logic signed [14:0] u, v, u0x, v0x;

    logic signed [14:0] r1_u, r1_v, r1_a, r1_b, r1_c, r1_e;
    logic [31:0]        r1_amp;

    logic signed [29:0] sq_u, sq_v, sq_a, sq_b, sq_c, sq_e;
    logic [OP_W-1:0]    r2_su, r2_sv, r2_sa, r2_sb, r2_sc, r2_se, r2_d02, r2_bw2;
    logic [31:0]        r2_amp;

    logic [OP_W-1:0]    r3_d2, r3_m1, r3_m2, r3_d02, r3_bw2;
    logic [31:0]        r3_amp;

    logic [OP_W-1:0]    diff;
    logic [OP_W-1:0]    n4_pa, n4_pb, n4_qa, n4_qb;
    logic [OP_W-1:0]    r4_pa, r4_pb, r4_qa, r4_qb;
    logic [31:0]        r4_amp;

    logic [PQ_W-1:0]    r5_p, r5_q;
    logic [31:0]        r5_amp;

    always_comb begin
        half_w = (32'(i_cfg.width) > MAX_SIDE) ? 12'(MAX_SIDE / 2) : i_cfg.width[12:1];
        half_h = (32'(i_cfg.height) > MAX_SIDE) ? 12'(MAX_SIDE / 2) : i_cfg.height[12:1];
        u   = $signed({3'b000, i_req.col}) - $signed({3'b000, half_w});
        v   = $signed({3'b000, i_req.row}) - $signed({3'b000, half_h});
        u0x = $signed({{2{i_cfg.notch_u0[12]}}, i_cfg.notch_u0});
        v0x = $signed({{2{i_cfg.notch_v0[12]}}, i_cfg.notch_v0});
    end

    always_comb begin
        sq_u = r1_u * r1_u;
        sq_v = r1_v * r1_v;
        sq_a = r1_a * r1_a;
        sq_b = r1_b * r1_b;
        sq_c = r1_c * r1_c;
        sq_e = r1_e * r1_e;
    end

    always_comb begin
        diff = (r3_d2 >= r3_d02) ? r3_d2 - r3_d02 : r3_d02 - r3_d2;
        unique case (i_cfg.filter_type)
            FT_HIGH: begin
                n4_pa = r3_d02; n4_pb = OP_W'(1);
                n4_qa = r3_d2;  n4_qb = OP_W'(1);
            end
            FT_BREJ, FT_BPASS: begin
                n4_pa = r3_d2; n4_pb = r3_bw2;
                n4_qa = diff;  n4_qb = diff;
            end
            FT_NOTCH: begin
                n4_pa = r3_d02; n4_pb = r3_d02;
                n4_qa = r3_m1;  n4_qb = r3_m2;
            end
            default: begin
                n4_pa = r3_d2;  n4_pb = OP_W'(1);
                n4_qa = r3_d02; n4_qb = OP_W'(1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_u   <= u;
            r1_v   <= v;
            r1_a   <= u - u0x;
            r1_b   <= v - v0x;
            r1_c   <= u + u0x;
            r1_e   <= v + v0x;
            r1_amp <= i_req.amplitude_in;

            r2_su  <= sq_u[OP_W-1:0];
            r2_sv  <= sq_v[OP_W-1:0];
            r2_sa  <= sq_a[OP_W-1:0];
            r2_sb  <= sq_b[OP_W-1:0];
            r2_sc  <= sq_c[OP_W-1:0];
            r2_se  <= sq_e[OP_W-1:0];
            r2_d02 <= OP_W'(i_cfg.cutoff) * OP_W'(i_cfg.cutoff);
            r2_bw2 <= OP_W'(i_cfg.bw_bins) * OP_W'(i_cfg.bw_bins);
            r2_amp <= r1_amp;

            r3_d2  <= r2_su + r2_sv;
            r3_m1  <= r2_sa + r2_sb;
            r3_m2  <= r2_sc + r2_se;
            r3_d02 <= r2_d02;
            r3_bw2 <= r2_bw2;
            r3_amp <= r2_amp;

            r4_pa  <= n4_pa;
            r4_pb  <= n4_pb;
            r4_qa  <= n4_qa;
            r4_qb  <= n4_qb;
            r4_amp <= r3_amp;

            r5_p   <= PQ_W'(r4_pa) * PQ_W'(r4_pb);
            r5_q   <= PQ_W'(r4_qa) * PQ_W'(r4_qb);
            r5_amp <= r4_amp;
        end
    end

    assign o_valid  = r_vld[4];
    assign o_pq.p   = r5_p;
    assign o_pq.q   = r5_q;
    assign o_pq.amp = r5_amp;

endmodule

[rtl/core/bsg_ratio_div.sv]
// Pipelined restoring divider: t = floor(P * 2^32 / Q), one quotient bit per stage,
// saturated to the cap. Depends on bsg_pkg.
module bsg_ratio_div
    import bsg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_pq  i_pq,
    output logic o_valid,
    output t_val o_val
);

    localparam int STAGES = QUO_W;

    typedef struct packed {
        logic [PQ_W-1:0]  rem;
        logic [PQ_W-1:0]  q;
        logic [T_INT-1:0] plow;
        logic [QUO_W-1:0] quo;
        logic             zero;
        logic             sat;
        logic [31:0]      amp;
    } t_dst;

    t_dst        r_st  [0:STAGES];
    t_dst        n_st  [0:STAGES];
    logic [PQ_W:0] trial [1:STAGES];
    logic [STAGES:0] r_vld;

    always_comb begin
        n_st[0].rem  = PQ_W'(i_pq.p[PQ_W-1:T_INT]);
        n_st[0].q    = i_pq.q;
        n_st[0].plow = i_pq.p[T_INT-1:0];
        n_st[0].quo  = '0;
        n_st[0].zero = (i_pq.q == '0);
        n_st[0].sat  = ({T_INT'(0), i_pq.p} >= {i_pq.q, T_INT'(0)});
        n_st[0].amp  = i_pq.amp;
        for (int k = 1; k <= STAGES; k++) begin
            trial[k]     = {r_st[k-1].rem, r_st[k-1].plow[T_INT-1]};
            n_st[k]      = r_st[k-1];
            n_st[k].plow = {r_st[k-1].plow[T_INT-2:0], 1'b0};
            if (trial[k] >= {1'b0, r_st[k-1].q}) begin
                n_st[k].rem = PQ_W'(trial[k] - {1'b0, r_st[k-1].q});
                n_st[k].quo = {r_st[k-1].quo[QUO_W-2:0], 1'b1};
            end else begin
                n_st[k].rem = trial[k][PQ_W-1:0];
                n_st[k].quo = {r_st[k-1].quo[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STAGES-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_valid    = r_vld[STAGES];
    assign o_val.val  = r_st[STAGES].sat ? T_CAP : {1'b0, r_st[STAGES].quo};
    assign o_val.zero = r_st[STAGES].zero;
    assign o_val.amp  = r_st[STAGES].amp;

endmodule

[rtl/core/bsg_power.sv]
// Raises t to the Butterworth order with a chain of fixed-point multiplies,
// two stages each (partial products, then sum and saturate). Depends on bsg_pkg.
module bsg_power
    import bsg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_val i_val,
    input  t_cfg i_cfg,
    output logic o_valid,
    output t_val o_val
);

    localparam int SPLIT  = 30;
    localparam int HI_W   = T_W - SPLIT;
    localparam int PROD_W = 2 * T_W;

    typedef struct packed {
        logic [T_W-1:0]        s;
        logic [T_W-1:0]        t;
        logic                  zero;
        logic [31:0]           amp;
    } t_pb;

    typedef struct packed {
        logic [T_W-1:0]        s;
        logic [T_W-1:0]        t;
        logic                  zero;
        logic [31:0]           amp;
        logic [2*SPLIT-1:0]    p00;
        logic [SPLIT+HI_W-1:0] p01;
        logic [SPLIT+HI_W-1:0] p10;
        logic [2*HI_W-1:0]     p11;
    } t_pa;

    t_pb                r_pb [0:MUL_COUNT];
    t_pb                n_pb [0:MUL_COUNT];
    t_pa                r_pa [1:MUL_COUNT];
    t_pa                n_pa [1:MUL_COUNT];
    logic [PROD_W-1:0]  prod [1:MUL_COUNT];
    logic [MUL_COUNT:0] r_vb;
    logic [MUL_COUNT:1] r_va;

    always_comb begin
        n_pb[0].s    = (i_cfg.order == 3'd0) ? (T_W'(1) << T_FRAC) : i_val.val;
        n_pb[0].t    = i_val.val;
        n_pb[0].zero = i_val.zero;
        n_pb[0].amp  = i_val.amp;
        for (int i = 1; i <= MUL_COUNT; i++) begin
            n_pa[i].s    = r_pb[i-1].s;
            n_pa[i].t    = r_pb[i-1].t;
            n_pa[i].zero = r_pb[i-1].zero;
            n_pa[i].amp  = r_pb[i-1].amp;
            n_pa[i].p00  = r_pb[i-1].s[SPLIT-1:0] * r_pb[i-1].t[SPLIT-1:0];
            n_pa[i].p01  = r_pb[i-1].s[SPLIT-1:0] * r_pb[i-1].t[T_W-1:SPLIT];
            n_pa[i].p10  = r_pb[i-1].s[T_W-1:SPLIT] * r_pb[i-1].t[SPLIT-1:0];
            n_pa[i].p11  = r_pb[i-1].s[T_W-1:SPLIT] * r_pb[i-1].t[T_W-1:SPLIT];

            prod[i] = (PROD_W'(r_pa[i].p11) << (2 * SPLIT))
                    + (PROD_W'(r_pa[i].p01) << SPLIT)
                    + (PROD_W'(r_pa[i].p10) << SPLIT)
                    + PROD_W'(r_pa[i].p00);
            n_pb[i].t    = r_pa[i].t;
            n_pb[i].zero = r_pa[i].zero;
            n_pb[i].amp  = r_pa[i].amp;
            if (3'(i) < i_cfg.order) begin
                n_pb[i].s = (|prod[i][PROD_W-1:QUO_W+T_FRAC]) ? T_CAP
                          : {1'b0, prod[i][QUO_W+T_FRAC-1:T_FRAC]};
            end else begin
                n_pb[i].s = r_pa[i].s;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= '0;
            r_va <= '0;
        end else if (i_en) begin
            r_vb[0] <= i_valid;
            for (int i = 1; i <= MUL_COUNT; i++) begin
                r_va[i] <= r_vb[i-1];
                r_vb[i] <= r_va[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pb <= n_pb;
            r_pa <= n_pa;
        end
    end

    assign o_valid    = r_vb[MUL_COUNT];
    assign o_val.val  = r_pb[MUL_COUNT].s;
    assign o_val.zero = r_pb[MUL_COUNT].zero;
    assign o_val.amp  = r_pb[MUL_COUNT].amp;

endmodule

[rtl/core/bsg_gain_out.sv]
// Gain divider floor(2^(F+32) / (2^32 + s)) one bit per stage, band-pass flip
// and amplitude scaling. Depends on bsg_pkg.
module bsg_gain_out
    import bsg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_val     i_val,
    input  t_cfg     i_cfg,
    output logic     o_valid,
    output t_out_rsp o_rsp
);

    localparam int STAGES = GAIN_W;
    localparam int AG_W   = 32 + GAIN_W;

    typedef struct packed {
        logic [T_W-1:0]    rem;
        logic [T_W-1:0]    d;
        logic [GAIN_W-1:0] quo;
        logic              rej0;
        logic [31:0]       amp;
    } t_gst;

    t_gst              r_st  [0:STAGES];
    t_gst              n_st  [0:STAGES];
    logic [T_W:0]      trial [1:STAGES];
    logic [STAGES+2:0] r_vld;

    logic [GAIN_W-1:0] reject, n_gain;
    logic [GAIN_W-1:0] r_gain, r_gain2;
    logic [31:0]       r_amp;
    logic [AG_W-1:0]   r_prod;

    always_comb begin
        n_st[0].rem  = T_W'(1) << (T_FRAC - 1);
        n_st[0].d    = (T_W'(1) << T_FRAC) + i_val.val;
        n_st[0].quo  = '0;
        n_st[0].rej0 = i_val.zero || (i_val.val >= T_CAP);
        n_st[0].amp  = i_val.amp;
        for (int k = 1; k <= STAGES; k++) begin
            trial[k] = {r_st[k-1].rem, 1'b0};
            n_st[k]  = r_st[k-1];
            if (trial[k] >= {1'b0, r_st[k-1].d}) begin
                n_st[k].rem = T_W'(trial[k] - {1'b0, r_st[k-1].d});
                n_st[k].quo = {r_st[k-1].quo[GAIN_W-2:0], 1'b1};
            end else begin
                n_st[k].rem = trial[k][T_W-1:0];
                n_st[k].quo = {r_st[k-1].quo[GAIN_W-2:0], 1'b0};
            end
        end
        reject = r_st[STAGES].rej0 ? '0 : r_st[STAGES].quo;
        n_gain = (i_cfg.filter_type == FT_BPASS) ? GAIN_ONE - reject : reject;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STAGES+1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st    <= n_st;
            r_gain  <= n_gain;
            r_amp   <= r_st[STAGES].amp;
            r_prod  <= AG_W'(r_amp) * AG_W'(r_gain);
            r_gain2 <= r_gain;
        end
    end

    assign o_valid             = r_vld[STAGES+2];
    assign o_rsp.amplitude_out = r_prod[GAIN_FRAC_BITS+31:GAIN_FRAC_BITS];
    assign o_rsp.gain          = r_gain2;

endmodule

[rtl/core/butterworth_spectrum_gain.sv]
// Butterworth frequency-domain gain: takes one spectrum amplitude per request with
// its column/row, returns the gain H (Q1.16) and amplitude * H. Fully pipelined:
// one request per clock while the result side is not stalling. The two dividers
// resolve one quotient bit per stage (58 for the ratio, 17 for the gain); the
// order-power chain has six two-stage multiplies. A stall on the result side
// freezes the whole pipeline. Depends on bsg_pkg, the macros and four submodules.
`include "butterworth_spectrum_gain_macros.svh"

module butterworth_spectrum_gain
    import bsg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_req              i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_rsp             o_out_rsp
);

    t_cfg r_cfg;
    logic en;
    logic f_valid, d_valid, p_valid;
    t_pq  f_pq;
    t_val d_val, p_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width       <= 13'd256;
            r_cfg.height      <= 13'd256;
            r_cfg.filter_type <= FT_LOW;
            r_cfg.cutoff      <= 13'd32;
            r_cfg.bw_bins     <= 13'd8;
            r_cfg.notch_u0    <= '0;
            r_cfg.notch_v0    <= '0;
            r_cfg.order       <= 3'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIDTH:      r_cfg.width       <= i_cfg_data;
                REG_HEIGHT:     r_cfg.height      <= i_cfg_data;
                REG_FILTER:     r_cfg.filter_type <= i_cfg_data[2:0];
                REG_CUTOFF:     r_cfg.cutoff      <= i_cfg_data;
                REG_BW_BINS:    r_cfg.bw_bins     <= i_cfg_data;
                REG_NOTCH_U0:   r_cfg.notch_u0    <= $signed(i_cfg_data);
                REG_NOTCH_V0:   r_cfg.notch_v0    <= $signed(i_cfg_data);
                REG_ORDER:      r_cfg.order       <= i_cfg_data[2:0];
            endcase
        end
    end

    assign o_in_stall = o_out_valid && i_out_stall;
    assign en         = !o_in_stall;

    bsg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_req   (i_in_req),
        .i_cfg   (r_cfg),
        .o_valid (f_valid),
        .o_pq    (f_pq)
    );

    bsg_ratio_div u_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_pq    (f_pq),
        .o_valid (d_valid),
        .o_val   (d_val)
    );

    bsg_power u_power (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d_valid),
        .i_val   (d_val),
        .i_cfg   (r_cfg),
        .o_valid (p_valid),
        .o_val   (p_val)
    );

    bsg_gain_out u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (p_valid),
        .i_val   (p_val),
        .i_cfg   (r_cfg),
        .o_valid (o_out_valid),
        .o_rsp   (o_out_rsp)
    );

    `BSG_ASSERT(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall |-> o_out_valid)
    `BSG_ASSERT(a_gain_range, i_clk, i_rst_n, o_out_valid |-> (o_out_rsp.gain <= GAIN_ONE))
    `BSG_ASSERT(a_zero_gain, i_clk, i_rst_n, (o_out_valid && o_out_rsp.gain == '0) |-> (o_out_rsp.amplitude_out == '0))
    `BSG_ASSERT_NEXT(a_cfg_order, i_clk, i_rst_n, i_cfg_we && i_cfg_idx == REG_ORDER, r_cfg.order == $past(i_cfg_data[2:0]))

endmodule
